// ----- rtl/fidc_pkg.sv -----
// Package for the irrigation dose controller: field widths, membership
// breakpoints, output singletons and the membership index codes.
// Used by every file under rtl; depends on nothing.
package fidc_pkg;

  // Input field widths
  localparam int MOIST_W = 10;
  localparam int EC_W    = 14;
  localparam int NUT_W   = 11;
  localparam int NPK_W   = 13;
  localparam int PH_W    = 11;
  localparam int DOSE_W  = 10;

  // Integer bits of each volume, in whole ml
  localparam int WATER_ML_W = 7;
  localparam int FERT_ML_W  = 6;

  // Widest distance inside a slope (largest span is 500)
  localparam int SPAN_W = 9;

  // Output singletons in ml
  localparam int unsigned WATER_ML_LOW  = 25;
  localparam int unsigned WATER_ML_MED  = 50;
  localparam int unsigned WATER_ML_HIGH = 100;
  localparam int unsigned FERT_ML_LOW   = 10;
  localparam int unsigned FERT_ML_MED   = 20;
  localparam int unsigned FERT_ML_HIGH  = 40;

  // Membership breakpoints
  localparam int MOIST_DRY_A = 200;
  localparam int MOIST_DRY_B = 400;
  localparam int MOIST_OPT_A = 300;
  localparam int MOIST_OPT_B = 400;
  localparam int MOIST_OPT_C = 600;
  localparam int MOIST_OPT_D = 700;
  localparam int MOIST_WET_A = 600;
  localparam int MOIST_WET_B = 800;
  localparam int EC_HIGH_A   = 1000;
  localparam int EC_HIGH_B   = 1500;
  localparam int EC_CAUT_A   = 1500;
  localparam int EC_CAUT_B   = 2000;
  localparam int NPK_LOW_A   = 150;
  localparam int NPK_LOW_B   = 300;
  localparam int NPK_HIGH_A  = 450;
  localparam int NPK_HIGH_B  = 600;
  localparam int PH_ACID_A   = 550;
  localparam int PH_ACID_B   = 650;
  localparam int PH_ALK_A    = 750;
  localparam int PH_ALK_B    = 850;
  localparam int DOSE_LOW_A  = 100;
  localparam int DOSE_LOW_B  = 300;
  localparam int DOSE_MED_A  = 200;
  localparam int DOSE_MED_B  = 500;
  localparam int DOSE_MED_C  = 500;
  localparam int DOSE_MED_D  = 800;
  localparam int DOSE_HIGH_A = 700;
  localparam int DOSE_HIGH_B = 900;

  // Membership degree index codes
  localparam int MF_DRY       = 0;
  localparam int MF_OPT       = 1;
  localparam int MF_WET       = 2;
  localparam int MF_EC_HIGH   = 3;
  localparam int MF_EC_CAUT   = 4;
  localparam int MF_NUT_LOW   = 5;
  localparam int MF_NUT_HIGH  = 6;
  localparam int MF_ACIDIC    = 7;
  localparam int MF_ALKALINE  = 8;
  localparam int MF_DOSE_LOW  = 9;
  localparam int MF_DOSE_MED  = 10;
  localparam int MF_DOSE_HIGH = 11;
  localparam int MF_COUNT     = 12;

endpackage

// ----- rtl/fidc_if.sv -----
// Valid/ready channel interfaces for the soil reading and the dose result.
// Depends on fidc_pkg for the field widths.
interface fidc_in_if;
  logic                         valid;
  logic                         ready;
  logic [fidc_pkg::MOIST_W-1:0] moisture_tenths;
  logic [fidc_pkg::EC_W-1:0]    conductivity;
  logic [fidc_pkg::NUT_W-1:0]   nitrogen;
  logic [fidc_pkg::NUT_W-1:0]   phosphorus;
  logic [fidc_pkg::NUT_W-1:0]   potassium;
  logic [fidc_pkg::PH_W-1:0]    acidity_hundredths;
  logic [fidc_pkg::DOSE_W-1:0]  dosage_tenths;

  modport source (output valid, moisture_tenths, conductivity, nitrogen, phosphorus,
                  potassium, acidity_hundredths, dosage_tenths, input ready);
  modport sink (input valid, moisture_tenths, conductivity, nitrogen, phosphorus,
                potassium, acidity_hundredths, dosage_tenths, output ready);
endinterface

interface fidc_out_if #(parameter int VOL_FRAC = 8);
  logic                                     valid;
  logic                                     ready;
  logic [fidc_pkg::WATER_ML_W+VOL_FRAC-1:0] water_volume;
  logic [fidc_pkg::FERT_ML_W+VOL_FRAC-1:0]  fertilizer_volume;

  modport source (output valid, water_volume, fertilizer_volume, input ready);
  modport sink (input valid, water_volume, fertilizer_volume, output ready);
endinterface

// ----- rtl/fidc_mf.sv -----
// One membership function over two register stages: shape select and
// reciprocal multiply, then remainder correction. Depends on fidc_pkg.
module fidc_mf #(
  parameter int DEG_FRAC = 16,
  parameter int VAL_W    = 10,
  parameter int HAS_RISE = 1,
  parameter int HAS_FALL = 1,
  parameter int PT_A     = 0,
  parameter int PT_B     = 1,
  parameter int PT_C     = 2,
  parameter int PT_D     = 3
) (
  input  logic                clk,
  input  logic                en,
  input  logic [VAL_W-1:0]    val,
  output logic [DEG_FRAC:0]   deg_o
);

  localparam int SPAN_W    = fidc_pkg::SPAN_W;
  localparam int M_W       = DEG_FRAC + SPAN_W;
  localparam int PROD_W    = M_W + SPAN_W;
  localparam int DEG_W     = DEG_FRAC + 1;
  localparam int RISE_SPAN = (HAS_RISE != 0) ? (PT_B - PT_A) : 1;
  localparam int FALL_SPAN = (HAS_FALL != 0) ? (PT_D - PT_C) : 1;
  localparam logic [M_W-1:0] RISE_M = M_W'((64'(1) << M_W) / RISE_SPAN);
  localparam logic [M_W-1:0] FALL_M = M_W'((64'(1) << M_W) / FALL_SPAN);
  localparam logic [M_W-1:0] RISE_SPAN_V = M_W'(RISE_SPAN);
  localparam logic [M_W-1:0] FALL_SPAN_V = M_W'(FALL_SPAN);

  typedef enum logic [1:0] {KIND_ZERO, KIND_ONE, KIND_SLOPE} kind_t;

  logic [31:0]       vx;
  kind_t             kind_nxt, kind_r;
  logic              fall_nxt, fall_r;
  logic [SPAN_W-1:0] dist_nxt, dist_r;
  logic [PROD_W-1:0] prod_nxt, prod_r;
  logic [M_W-1:0]    q0, x, span, qs, rem, quo;
  logic [DEG_W-1:0]  deg_nxt, deg_r;

  // Classify the value and start the reciprocal multiply
  always_comb begin
    vx       = 32'(val);
    kind_nxt = KIND_ONE;
    fall_nxt = 1'b0;
    dist_nxt = '0;
    if (HAS_RISE != 0 && vx <= 32'(PT_A)) begin
      kind_nxt = KIND_ZERO;
    end else if (HAS_FALL != 0 && vx >= 32'(PT_D)) begin
      kind_nxt = KIND_ZERO;
    end else if (HAS_RISE != 0 && vx < 32'(PT_B)) begin
      kind_nxt = KIND_SLOPE;
      dist_nxt = SPAN_W'(vx - 32'(PT_A));
    end else if (HAS_FALL != 0 && vx > 32'(PT_C)) begin
      kind_nxt = KIND_SLOPE;
      fall_nxt = 1'b1;
      dist_nxt = SPAN_W'(32'(PT_D) - vx);
    end
    prod_nxt = PROD_W'(dist_nxt) * PROD_W'(fall_nxt ? FALL_M : RISE_M);
  end

  // Correct the estimate by one step
  always_comb begin
    q0   = prod_r[PROD_W-1:SPAN_W];
    x    = {dist_r, {DEG_FRAC{1'b0}}};
    span = fall_r ? FALL_SPAN_V : RISE_SPAN_V;
    qs   = q0 * span;
    rem  = x - qs;
    quo  = (rem >= span) ? q0 + M_W'(1) : q0;
    unique case (kind_r)
      KIND_ZERO:  deg_nxt = '0;
      KIND_ONE:   deg_nxt = DEG_W'(1) << DEG_FRAC;
      KIND_SLOPE: deg_nxt = DEG_W'(quo);
      default:    deg_nxt = '0;
    endcase
  end

  // Advance both stages on enable
  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_nxt;
      fall_r <= fall_nxt;
      dist_r <= dist_nxt;
      prod_r <= prod_nxt;
      deg_r  <= deg_nxt;
    end
  end

  assign deg_o = deg_r;

endmodule

// ----- rtl/fidc_rules.sv -----
// Rule base stage: min/max of the degrees into singleton weights, then the
// weight sums and weighted singleton sums. Depends on fidc_pkg.
module fidc_rules #(
  parameter int DEG_FRAC = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [DEG_FRAC:0]       deg_i [fidc_pkg::MF_COUNT],
  output logic                    vld_o,
  output logic [DEG_FRAC+7:0]     water_acc_o,
  output logic [DEG_FRAC+2:0]     water_sum_o,
  output logic [DEG_FRAC+7:0]     fert_acc_o,
  output logic [DEG_FRAC+2:0]     fert_sum_o
);

  localparam int DEG_W = DEG_FRAC + 1;
  localparam int SUM_W = DEG_FRAC + 3;
  localparam int ACC_W = DEG_FRAC + 8;

  function automatic logic [DEG_W-1:0] dmin(input logic [DEG_W-1:0] a,
                                            input logic [DEG_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [DEG_W-1:0] dmax(input logic [DEG_W-1:0] a,
                                            input logic [DEG_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [DEG_W-1:0] ww0, ww1, ww2, ww3, wf0, wf1, wf2, wf3;
  logic [ACC_W-1:0] water_acc_nxt, water_acc_r, fert_acc_nxt, fert_acc_r;
  logic [SUM_W-1:0] water_sum_nxt, water_sum_r, fert_sum_nxt, fert_sum_r;
  logic             vld_r;

  // Fire the rules and form the sums
  always_comb begin
    ww0 = dmax(deg_i[fidc_pkg::MF_WET],
               dmin(deg_i[fidc_pkg::MF_WET], deg_i[fidc_pkg::MF_EC_HIGH]));
    ww1 = deg_i[fidc_pkg::MF_OPT];
    ww2 = deg_i[fidc_pkg::MF_EC_HIGH];
    ww3 = deg_i[fidc_pkg::MF_DRY];
    wf0 = dmax(dmax(deg_i[fidc_pkg::MF_NUT_HIGH], deg_i[fidc_pkg::MF_EC_HIGH]),
               dmin(deg_i[fidc_pkg::MF_WET], deg_i[fidc_pkg::MF_EC_CAUT]));
    wf1 = deg_i[fidc_pkg::MF_DOSE_LOW];
    wf2 = dmax(dmin(deg_i[fidc_pkg::MF_DOSE_MED], deg_i[fidc_pkg::MF_NUT_LOW]),
               dmax(deg_i[fidc_pkg::MF_ACIDIC], deg_i[fidc_pkg::MF_ALKALINE]));
    wf3 = dmin(deg_i[fidc_pkg::MF_DOSE_HIGH], deg_i[fidc_pkg::MF_NUT_LOW]);

    water_sum_nxt = SUM_W'(ww0) + SUM_W'(ww1) + SUM_W'(ww2) + SUM_W'(ww3);
    fert_sum_nxt  = SUM_W'(wf0) + SUM_W'(wf1) + SUM_W'(wf2) + SUM_W'(wf3);
    water_acc_nxt = ACC_W'(ww1) * ACC_W'(fidc_pkg::WATER_ML_LOW)
                  + ACC_W'(ww2) * ACC_W'(fidc_pkg::WATER_ML_MED)
                  + ACC_W'(ww3) * ACC_W'(fidc_pkg::WATER_ML_HIGH);
    fert_acc_nxt  = ACC_W'(wf1) * ACC_W'(fidc_pkg::FERT_ML_LOW)
                  + ACC_W'(wf2) * ACC_W'(fidc_pkg::FERT_ML_MED)
                  + ACC_W'(wf3) * ACC_W'(fidc_pkg::FERT_ML_HIGH);
  end

  // Hold the sums
  always_ff @(posedge clk) begin
    if (en) begin
      water_acc_r <= water_acc_nxt;
      water_sum_r <= water_sum_nxt;
      fert_acc_r  <= fert_acc_nxt;
      fert_sum_r  <= fert_sum_nxt;
    end
  end

  // Carry the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  assign vld_o       = vld_r;
  assign water_acc_o = water_acc_r;
  assign water_sum_o = water_sum_r;
  assign fert_acc_o  = fert_acc_r;
  assign fert_sum_o  = fert_sum_r;

endmodule

// ----- rtl/fidc_div.sv -----
// Pipelined restoring divider for the weighted average: one quotient bit
// per stage, zero weight sum gives zero. Depends on fidc_pkg.
module fidc_div #(
  parameter int DEG_FRAC = 16,
  parameter int VOL_FRAC = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     vld_i,
  input  logic [DEG_FRAC+7:0]                      acc_i,
  input  logic [DEG_FRAC+2:0]                      sum_i,
  output logic                                     vld_o,
  output logic [fidc_pkg::WATER_ML_W+VOL_FRAC-1:0] quo_o
);

  localparam int PRE_W = fidc_pkg::WATER_ML_W;
  localparam int QUO_W = PRE_W + VOL_FRAC;
  localparam int SUM_W = DEG_FRAC + 3;

  logic [SUM_W-1:0] rem_s  [QUO_W+1];
  logic [QUO_W-1:0] nbit_s [QUO_W+1];
  logic [QUO_W-1:0] quo_s  [QUO_W+1];
  logic [SUM_W-1:0] sum_s  [QUO_W+1];
  logic             zero_s [QUO_W+1];
  logic             vld_s  [QUO_W+1];

  // Load the upper numerator part as the first remainder
  assign rem_s[0]  = SUM_W'(acc_i >> PRE_W);
  assign nbit_s[0] = {acc_i[PRE_W-1:0], {VOL_FRAC{1'b0}}};
  assign quo_s[0]  = '0;
  assign sum_s[0]  = sum_i;
  assign zero_s[0] = (sum_i == '0);
  assign vld_s[0]  = vld_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [SUM_W:0] trial;
    logic           ge;

    // Shift in one numerator bit and try the subtract
    always_comb begin
      trial = {rem_s[k], nbit_s[k][QUO_W-1]};
      ge    = (trial >= {1'b0, sum_s[k]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= ge ? SUM_W'(trial - {1'b0, sum_s[k]}) : SUM_W'(trial);
        nbit_s[k+1] <= nbit_s[k] << 1;
        quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], ge};
        sum_s[k+1]  <= sum_s[k];
        zero_s[k+1] <= zero_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end
  end

  assign vld_o = vld_s[QUO_W];
  assign quo_o = zero_s[QUO_W] ? '0 : quo_s[QUO_W];

endmodule

// ----- rtl/fuzzy_irrigation_dose_controller_top.sv -----
// Top level of the fuzzy irrigation dose controller: membership, rules and
// two dividers. Depends on fidc_pkg, fidc_if, fidc_mf, fidc_rules, fidc_div.

// One soil reading in, one water and fertilizer dose out, every reading on its
// own. A reading can enter every clock cycle while no result waits at the
// output; its result passes through the two membership stages, one rule
// stage and one divider stage per quotient bit.
// The whole pipeline advances together and holds while a finished result waits
// for out_ch.ready, so the input is ready whenever the output word is empty
// or being taken.
module fuzzy_irrigation_dose_controller_top #(
  parameter int DEGREE_FRAC_BITS = 16,
  parameter int VOLUME_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  fidc_in_if.sink    in_ch,
  fidc_out_if.source out_ch
);

  localparam int DEG_W   = DEGREE_FRAC_BITS + 1;
  localparam int SUM_W   = DEGREE_FRAC_BITS + 3;
  localparam int ACC_W   = DEGREE_FRAC_BITS + 8;
  localparam int WATER_W = fidc_pkg::WATER_ML_W + VOLUME_FRAC_BITS;
  localparam int FERT_W  = fidc_pkg::FERT_ML_W + VOLUME_FRAC_BITS;

  logic                       en;
  logic                       vld1_r, vld2_r, rules_vld;
  logic [fidc_pkg::NPK_W-1:0] npk;
  logic [DEG_W-1:0]           deg [fidc_pkg::MF_COUNT];
  logic [ACC_W-1:0]           water_acc, fert_acc;
  logic [SUM_W-1:0]           water_sum, fert_sum;
  logic                       water_vld, fert_vld;
  logic [WATER_W-1:0]         water_quo, fert_quo;

  // Advance the pipeline unless a result word is stuck at the output
  assign en           = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;

  assign npk = fidc_pkg::NPK_W'(in_ch.nitrogen) + fidc_pkg::NPK_W'(in_ch.phosphorus)
             + fidc_pkg::NPK_W'(in_ch.potassium);

  // Carry valid through the membership stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_ch.valid;
      vld2_r <= vld1_r;
    end
  end

  // Membership functions
  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::MOIST_W), .HAS_RISE(0),
    .HAS_FALL(1), .PT_A(0), .PT_B(0), .PT_C(fidc_pkg::MOIST_DRY_A),
    .PT_D(fidc_pkg::MOIST_DRY_B))
  u_dry (.clk(clk), .en(en), .val(in_ch.moisture_tenths), .deg_o(deg[fidc_pkg::MF_DRY]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::MOIST_W), .HAS_RISE(1),
    .HAS_FALL(1), .PT_A(fidc_pkg::MOIST_OPT_A), .PT_B(fidc_pkg::MOIST_OPT_B),
    .PT_C(fidc_pkg::MOIST_OPT_C), .PT_D(fidc_pkg::MOIST_OPT_D))
  u_opt (.clk(clk), .en(en), .val(in_ch.moisture_tenths), .deg_o(deg[fidc_pkg::MF_OPT]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::MOIST_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::MOIST_WET_A), .PT_B(fidc_pkg::MOIST_WET_B),
    .PT_C(0), .PT_D(0))
  u_wet (.clk(clk), .en(en), .val(in_ch.moisture_tenths), .deg_o(deg[fidc_pkg::MF_WET]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::EC_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::EC_HIGH_A), .PT_B(fidc_pkg::EC_HIGH_B),
    .PT_C(0), .PT_D(0))
  u_ec_high (.clk(clk), .en(en), .val(in_ch.conductivity),
    .deg_o(deg[fidc_pkg::MF_EC_HIGH]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::EC_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::EC_CAUT_A), .PT_B(fidc_pkg::EC_CAUT_B),
    .PT_C(0), .PT_D(0))
  u_ec_caut (.clk(clk), .en(en), .val(in_ch.conductivity),
    .deg_o(deg[fidc_pkg::MF_EC_CAUT]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::NPK_W), .HAS_RISE(0),
    .HAS_FALL(1), .PT_A(0), .PT_B(0), .PT_C(fidc_pkg::NPK_LOW_A),
    .PT_D(fidc_pkg::NPK_LOW_B))
  u_nut_low (.clk(clk), .en(en), .val(npk), .deg_o(deg[fidc_pkg::MF_NUT_LOW]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::NPK_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::NPK_HIGH_A), .PT_B(fidc_pkg::NPK_HIGH_B),
    .PT_C(0), .PT_D(0))
  u_nut_high (.clk(clk), .en(en), .val(npk), .deg_o(deg[fidc_pkg::MF_NUT_HIGH]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::PH_W), .HAS_RISE(0),
    .HAS_FALL(1), .PT_A(0), .PT_B(0), .PT_C(fidc_pkg::PH_ACID_A),
    .PT_D(fidc_pkg::PH_ACID_B))
  u_acidic (.clk(clk), .en(en), .val(in_ch.acidity_hundredths),
    .deg_o(deg[fidc_pkg::MF_ACIDIC]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::PH_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::PH_ALK_A), .PT_B(fidc_pkg::PH_ALK_B),
    .PT_C(0), .PT_D(0))
  u_alkaline (.clk(clk), .en(en), .val(in_ch.acidity_hundredths),
    .deg_o(deg[fidc_pkg::MF_ALKALINE]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::DOSE_W), .HAS_RISE(0),
    .HAS_FALL(1), .PT_A(0), .PT_B(0), .PT_C(fidc_pkg::DOSE_LOW_A),
    .PT_D(fidc_pkg::DOSE_LOW_B))
  u_dose_low (.clk(clk), .en(en), .val(in_ch.dosage_tenths),
    .deg_o(deg[fidc_pkg::MF_DOSE_LOW]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::DOSE_W), .HAS_RISE(1),
    .HAS_FALL(1), .PT_A(fidc_pkg::DOSE_MED_A), .PT_B(fidc_pkg::DOSE_MED_B),
    .PT_C(fidc_pkg::DOSE_MED_C), .PT_D(fidc_pkg::DOSE_MED_D))
  u_dose_med (.clk(clk), .en(en), .val(in_ch.dosage_tenths),
    .deg_o(deg[fidc_pkg::MF_DOSE_MED]));

  fidc_mf #(.DEG_FRAC(DEGREE_FRAC_BITS), .VAL_W(fidc_pkg::DOSE_W), .HAS_RISE(1),
    .HAS_FALL(0), .PT_A(fidc_pkg::DOSE_HIGH_A), .PT_B(fidc_pkg::DOSE_HIGH_B),
    .PT_C(0), .PT_D(0))
  u_dose_high (.clk(clk), .en(en), .val(in_ch.dosage_tenths),
    .deg_o(deg[fidc_pkg::MF_DOSE_HIGH]));

  // Rule base and sums
  fidc_rules #(.DEG_FRAC(DEGREE_FRAC_BITS)) u_rules (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(vld2_r), .deg_i(deg),
    .vld_o(rules_vld), .water_acc_o(water_acc), .water_sum_o(water_sum),
    .fert_acc_o(fert_acc), .fert_sum_o(fert_sum));

  // Weighted averages
  fidc_div #(.DEG_FRAC(DEGREE_FRAC_BITS), .VOL_FRAC(VOLUME_FRAC_BITS)) u_div_water (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(rules_vld), .acc_i(water_acc),
    .sum_i(water_sum), .vld_o(water_vld), .quo_o(water_quo));

  fidc_div #(.DEG_FRAC(DEGREE_FRAC_BITS), .VOL_FRAC(VOLUME_FRAC_BITS)) u_div_fert (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(rules_vld), .acc_i(fert_acc),
    .sum_i(fert_sum), .vld_o(fert_vld), .quo_o(fert_quo));

  // Drive the result word
  assign out_ch.valid             = water_vld;
  assign out_ch.water_volume      = water_quo;
  assign out_ch.fertilizer_volume = FERT_W'(fert_quo);

  // Both divider pipelines stay in step
  assert property (@(posedge clk) disable iff (!rst_n) water_vld == fert_vld)
    else $error("divider valid bits out of step");

  // Volumes never exceed their largest singleton
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (WATER_W'(water_quo) <=
      WATER_W'(fidc_pkg::WATER_ML_HIGH << VOLUME_FRAC_BITS)))
    else $error("water volume above its top singleton");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (fert_quo <= WATER_W'(fidc_pkg::FERT_ML_HIGH << VOLUME_FRAC_BITS)))
    else $error("fertilizer volume above its top singleton");

  // Nothing comes out straight after reset
  assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result word valid straight after reset");

endmodule
